// File: hw/rtl/config_line_tokenizer_top_assert.svh
// Assertion macros for the configuration line tokenizer.
// Used by ctok_checker; needs no other file.
`ifndef CONFIG_LINE_TOKENIZER_TOP_ASSERT_SVH
`define CONFIG_LINE_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, silent during reset.
`define CTOK_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ctok assertion failed");

// Next-cycle implication, also checked through reset.
`define CTOK_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ctok assertion failed");

`endif

// File: hw/rtl/ctok_pkg.sv
// Shared types and codes for the configuration line tokenizer.
// No dependencies; used by the top level, its checker and the bench.
package ctok_pkg;

  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned LimitW    = 6;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] REG_STRING_LIMIT = 1'd0;
  localparam logic [CfgIndexW-1:0] REG_WORD_LIMIT   = 1'd1;

  localparam logic [2:0] KIND_TEXT   = 3'd0;
  localparam logic [2:0] KIND_END    = 3'd1;
  localparam logic [2:0] KIND_ASSIGN = 3'd2;
  localparam logic [2:0] KIND_STRING = 3'd3;
  localparam logic [2:0] KIND_INT    = 3'd4;
  localparam logic [2:0] KIND_BOOL   = 3'd5;
  localparam logic [2:0] KIND_WORD   = 3'd6;
  localparam logic [2:0] KIND_ERROR  = 3'd7;

  localparam logic [1:0] ERR_OPEN_STRING = 2'd0;
  localparam logic [1:0] ERR_STRING_LONG = 2'd1;
  localparam logic [1:0] ERR_WORD_LONG   = 2'd2;
  localparam logic [1:0] ERR_BAD_CHAR    = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  text_byte;
    logic [31:0] value;
    logic [5:0]  length;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

endpackage

// File: hw/rtl/config_line_tokenizer_top.sv
// Top level of the configuration line tokenizer.
// Depends on ctok_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / ch) carries one line character per
//   word; a zero character ends the line. Output channel (out_valid /
//   out_stall / kind ... last) carries one result per word. A character
//   gives zero, one or two results; last marks the final one it caused.
//   Configuration: write string_limit (index 0) or word_limit (index 1) with
//   cfg_we while the block is idle.
// Data path: a character is held in the input register, is decoded into
//   the result queue once the queue has room, and its first result is
//   offered on the outputs once it reaches the head of the queue.
// Throughput: one character per cycle while each gives at most one result
//   and out_stall stays low; a character that gives two results pushes two
//   entries. The four-entry result queue and its single read port set that figure.
// Reset: rst (synchronous) empties the queue and input register, returns
//   the tokenizer to idle and the limits to 50 and 40.
// Stall: out_stall holds the head result; the queue keeps filling until
//   fewer than two entries are free, then in_stall rises.
module config_line_tokenizer_top
  import ctok_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           ch,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           kind,
  output logic [7:0]           text_byte,
  output logic [31:0]          value,
  output logic [5:0]           length,
  output logic [1:0]           error_code,
  output logic                 last,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [LimitW-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_STRING  = 3'd1,
    M_INTEGER = 3'd2,
    M_WORD    = 3'd3,
    M_COMMENT = 3'd4,
    M_SKIP    = 3'd5
  } mode_t;

  // keyword_match: 0 none, 1..4 prefix of true, 5..9 prefix of false
  localparam logic [3:0] KW_NONE       = 4'd0;
  localparam logic [3:0] KW_TRUE_T     = 4'd1;
  localparam logic [3:0] KW_TRUE_FULL  = 4'd4;
  localparam logic [3:0] KW_FALSE_F    = 4'd5;
  localparam logic [3:0] KW_FALSE_FULL = 4'd9;

  function automatic result_t mk_result(input logic [2:0] k, input logic [7:0] tb,
                                        input logic [31:0] v, input logic [5:0] len,
                                        input logic [1:0] err);
    result_t r;
    r.kind       = k;
    r.text_byte  = tb;
    r.value      = v;
    r.length     = len;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [3:0] next_match(input logic [3:0] m, input logic [7:0] c);
    logic [3:0] n;
    n = KW_NONE;
    case (m)
      4'd1: if (c == "r") n = 4'd2;
      4'd2: if (c == "u") n = 4'd3;
      4'd3: if (c == "e") n = 4'd4;
      4'd5: if (c == "a") n = 4'd6;
      4'd6: if (c == "l") n = 4'd7;
      4'd7: if (c == "s") n = 4'd8;
      4'd8: if (c == "e") n = 4'd9;
      default: n = KW_NONE;
    endcase
    return n;
  endfunction

  // Configuration registers
  logic [LimitW-1:0] string_limit;
  logic [LimitW-1:0] word_limit;

  // Tokenizer state
  mode_t       mode, mode_next;
  logic [31:0] accumulator, accumulator_next;
  logic [5:0]  token_length, token_length_next;
  logic [3:0]  keyword_match, keyword_match_next;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_ch;

  // Result queue
  result_t    queue [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  logic       room, fire, in_take, out_take;
  result_t    res_a, res_b;
  logic       res_a_v, res_b_v;
  logic       handle_idle;
  logic [5:0] len_grown;

  assign room     = (count <= 3'd2);
  assign fire     = s1_valid && room;
  assign in_stall = s1_valid && !room;
  assign in_take  = in_valid && !in_stall;
  assign out_valid = (count != 3'd0);
  assign out_take = out_valid && !out_stall;

  assign len_grown = (token_length == 6'd63) ? token_length : 6'(token_length + 6'd1);

  // Decode one character against the current state: a pending token from
  // the mode (res_a) and then the idle handling of the same character (res_b).
  always_comb begin
    mode_next          = mode;
    accumulator_next   = accumulator;
    token_length_next  = token_length;
    keyword_match_next = keyword_match;
    handle_idle        = 1'b0;
    res_a   = mk_result(KIND_TEXT, 8'd0, 32'd0, 6'd0, ERR_OPEN_STRING);
    res_b   = res_a;
    res_a_v = 1'b0;
    res_b_v = 1'b0;

    case (mode)
      M_STRING: begin
        res_a_v = 1'b1;
        if (s1_ch == "\"") begin
          if (token_length >= string_limit) begin
            res_a     = mk_result(KIND_ERROR, 8'd0, 32'd0, 6'd0, ERR_STRING_LONG);
            mode_next = M_SKIP;
          end else begin
            res_a     = mk_result(KIND_STRING, 8'd0, 32'd0, token_length, ERR_OPEN_STRING);
            mode_next = M_IDLE;
          end
        end else if (s1_ch == 8'd0) begin
          res_a     = mk_result(KIND_ERROR, 8'd0, 32'd0, 6'd0, ERR_OPEN_STRING);
          mode_next = M_IDLE;
        end else begin
          res_a             = mk_result(KIND_TEXT, s1_ch, 32'd0, 6'd0, ERR_OPEN_STRING);
          token_length_next = len_grown;
        end
      end
      M_COMMENT, M_SKIP: begin
        if (s1_ch == 8'd0) mode_next = M_IDLE;
      end
      M_INTEGER: begin
        if (is_digit(s1_ch)) begin
          // times ten as two shifts and an add, then the digit
          accumulator_next = (accumulator << 3) + (accumulator << 1) + {28'd0, s1_ch[3:0]};
        end else begin
          res_a       = mk_result(KIND_INT, 8'd0, accumulator, 6'd0, ERR_OPEN_STRING);
          res_a_v     = 1'b1;
          mode_next   = M_IDLE;
          handle_idle = 1'b1;
        end
      end
      M_WORD: begin
        res_a_v = 1'b1;
        if (is_alpha(s1_ch) || is_digit(s1_ch) || (s1_ch == "-") || (s1_ch == "_")) begin
          res_a              = mk_result(KIND_TEXT, s1_ch, 32'd0, 6'd0, ERR_OPEN_STRING);
          token_length_next  = len_grown;
          keyword_match_next = next_match(keyword_match, s1_ch);
        end else if (keyword_match == KW_TRUE_FULL) begin
          res_a       = mk_result(KIND_BOOL, 8'd0, 32'd1, token_length, ERR_OPEN_STRING);
          mode_next   = M_IDLE;
          handle_idle = 1'b1;
        end else if (keyword_match == KW_FALSE_FULL) begin
          res_a       = mk_result(KIND_BOOL, 8'd0, 32'd0, token_length, ERR_OPEN_STRING);
          mode_next   = M_IDLE;
          handle_idle = 1'b1;
        end else if (token_length >= word_limit) begin
          res_a     = mk_result(KIND_ERROR, 8'd0, 32'd0, 6'd0, ERR_WORD_LONG);
          mode_next = (s1_ch == 8'd0) ? M_IDLE : M_SKIP;
        end else begin
          res_a       = mk_result(KIND_WORD, 8'd0, 32'd0, token_length, ERR_OPEN_STRING);
          mode_next   = M_IDLE;
          handle_idle = 1'b1;
        end
      end
      default: begin
        mode_next   = M_IDLE;
        handle_idle = 1'b1;
      end
    endcase

    if (handle_idle) begin
      if (is_space(s1_ch)) begin
        // skip whitespace
      end else if (s1_ch == 8'd0) begin
        res_b   = mk_result(KIND_END, 8'd0, 32'd0, 6'd0, ERR_OPEN_STRING);
        res_b_v = 1'b1;
      end else if (s1_ch == "#") begin
        res_b     = mk_result(KIND_END, 8'd0, 32'd0, 6'd0, ERR_OPEN_STRING);
        res_b_v   = 1'b1;
        mode_next = M_COMMENT;
      end else if (s1_ch == "=") begin
        res_b   = mk_result(KIND_ASSIGN, 8'd0, 32'd0, 6'd0, ERR_OPEN_STRING);
        res_b_v = 1'b1;
      end else if (s1_ch == "\"") begin
        mode_next         = M_STRING;
        token_length_next = 6'd0;
      end else if (is_digit(s1_ch)) begin
        accumulator_next = {28'd0, s1_ch[3:0]};
        mode_next        = M_INTEGER;
      end else if (is_alpha(s1_ch)) begin
        res_b              = mk_result(KIND_TEXT, s1_ch, 32'd0, 6'd0, ERR_OPEN_STRING);
        res_b_v            = 1'b1;
        mode_next          = M_WORD;
        token_length_next  = 6'd1;
        keyword_match_next = (s1_ch == "t") ? KW_TRUE_T :
                             (s1_ch == "f") ? KW_FALSE_F : KW_NONE;
      end else begin
        res_b     = mk_result(KIND_ERROR, s1_ch, 32'd0, 6'd0, ERR_BAD_CHAR);
        res_b_v   = 1'b1;
        mode_next = M_SKIP;
      end
    end

    // flag the final result of this character
    if (res_b_v) res_b.last = 1'b1;
    else         res_a.last = 1'b1;
  end

  // Configuration, input register and tokenizer state
  always_ff @(posedge clk) begin
    if (rst) begin
      string_limit  <= 6'd50;
      word_limit    <= 6'd40;
      mode          <= M_IDLE;
      accumulator   <= 32'd0;
      token_length  <= 6'd0;
      keyword_match <= KW_NONE;
      s1_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STRING_LIMIT: string_limit <= cfg_data;
          REG_WORD_LIMIT:   word_limit   <= cfg_data;
          default: ;
        endcase
      end
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        mode          <= mode_next;
        accumulator   <= accumulator_next;
        token_length  <= token_length_next;
        keyword_match <= keyword_match_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_ch <= ch;
  end

  // Result queue: push up to two, pop one per cycle while out_valid and not out_stall
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + (fire ? {1'b0, res_a_v} + {1'b0, res_b_v} : 2'd0);
      rd_ptr <= rd_ptr + {1'b0, out_take};
      count  <= count + (fire ? {2'b0, res_a_v} + {2'b0, res_b_v} : 3'd0)
                - {2'b0, out_take};
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_a_v) queue[wr_ptr] <= res_a;
    if (fire && res_b_v) queue[wr_ptr + {1'b0, res_a_v}] <= res_b;
  end

  assign kind       = queue[rd_ptr].kind;
  assign text_byte  = queue[rd_ptr].text_byte;
  assign value      = queue[rd_ptr].value;
  assign length     = queue[rd_ptr].length;
  assign error_code = queue[rd_ptr].error_code;
  assign last       = queue[rd_ptr].last;

endmodule

// File: hw/rtl/ctok_checker.sv
// Port-level checks for the configuration line tokenizer, bound to the top.
// Depends on ctok_pkg and config_line_tokenizer_top_assert.svh.
`include "config_line_tokenizer_top_assert.svh"

module ctok_checker
  import ctok_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  kind,
  input logic [31:0] value,
  input logic        last
);

  // Kinds that a token ended by the next character can carry.
  logic pending_kind;
  assign pending_kind = (kind == KIND_INT) || (kind == KIND_BOOL) || (kind == KIND_WORD);

  // A stalled result stays offered.
  `CTOK_ASSERT_NEXT(a_out_hold, clk, !rst && out_valid && out_stall, out_valid)

  // Reset leaves nothing queued and the input open.
  `CTOK_ASSERT_NEXT(a_reset_empty, clk, rst, !out_valid && !in_stall)

  // Only a token ended by the next character can be followed by another result.
  `CTOK_ASSERT_SAME(a_last_mark, clk, rst, out_valid && !pending_kind, last)

  // A boolean carries only 0 or 1.
  `CTOK_ASSERT_SAME(a_bool_value, clk, rst, out_valid && kind == KIND_BOOL, value[31:1] == 31'd0)

endmodule

bind config_line_tokenizer_top ctok_checker u_ctok_checker (.*);

// File: sim/config_line_tokenizer_top_tb.sv
// Self-checking bench for config_line_tokenizer_top: directed lines, then random lines.
// Predicts result words from its own model or typed rows; depends on ctok_pkg and the RTL.
`timescale 1ns / 100ps

module config_line_tokenizer_top_tb
  import ctok_pkg::*;
();

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES      = 6;
  localparam int REPORT_MAX      = 10;

  localparam logic [1:0] NO_ERROR = 2'd0;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LOWER = 8'h61;

  // Keyword progress: 1..4 track "true", 5..9 track "false".
  localparam logic [3:0] KW_NONE       = 4'd0;
  localparam logic [3:0] KW_TRUE_START = 4'd1;
  localparam logic [3:0] KW_TRUE_DONE  = 4'd4;
  localparam logic [3:0] KW_FALSE_START = 4'd5;
  localparam logic [3:0] KW_FALSE_DONE = 4'd9;
  localparam logic [31:0] TRUE_TEXT  = "true";
  localparam logic [39:0] FALSE_TEXT = "false";

  typedef enum logic [2:0] {
    PM_IDLE, PM_STRING, PM_INTEGER, PM_WORD, PM_COMMENT, PM_SKIP
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] c;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam result_t NO_TOKEN = '0;

  // Directed lines; typed expectations only for reset-time, extreme and error rows.
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{CH_NUL,   1'b1, '{KIND_END, 8'd0, 32'd0, 6'd0, NO_ERROR, 1'b1}},
    '{8'hFF,    1'b1, '{KIND_ERROR, 8'hFF, 32'd0, 6'd0, ERR_BAD_CHAR, 1'b1}},
    '{CH_NUL,   1'b0, NO_TOKEN},
    '{"t",      1'b0, NO_TOKEN},
    '{"r",      1'b0, NO_TOKEN},
    '{"u",      1'b0, NO_TOKEN},
    '{"e",      1'b0, NO_TOKEN},
    '{CH_EQUAL, 1'b0, NO_TOKEN},
    '{CH_QUOTE, 1'b0, NO_TOKEN},
    '{CH_QUOTE, 1'b0, NO_TOKEN},
    '{"4",      1'b0, NO_TOKEN},
    '{"2",      1'b0, NO_TOKEN},
    '{CH_EQUAL, 1'b0, NO_TOKEN},
    '{CH_QUOTE, 1'b0, NO_TOKEN},
    '{"b",      1'b0, NO_TOKEN},
    '{CH_NUL,   1'b1, '{KIND_ERROR, 8'd0, 32'd0, 6'd0, ERR_OPEN_STRING, 1'b1}},
    '{"f",      1'b0, NO_TOKEN},
    '{"a",      1'b0, NO_TOKEN},
    '{"l",      1'b0, NO_TOKEN},
    '{"s",      1'b0, NO_TOKEN},
    '{"e",      1'b0, NO_TOKEN},
    '{CH_TAB,   1'b0, NO_TOKEN},
    '{"x",      1'b0, NO_TOKEN},
    '{CH_HASH,  1'b0, NO_TOKEN},
    '{CH_NUL,   1'b0, NO_TOKEN}
  };

  string keyword_forms[$] = '{"true", "false", "tru", "fals", "truex", "falsey",
                              "t", "f", "True", "false_"};

  // Limits per phase: {string_limit, word_limit, sender idle %, receiver stall %}.
  // Phase 0 keeps the reset limits; the last phase draws random limits.
  int phase_plan [NUM_PHASES][4] = '{
    '{50, 40,  0,  0},
    '{ 1,  1, 47,  0},
    '{63, 63,  0, 47},
    '{ 0,  0, 31, 31},
    '{ 5,  3,  0,  0},
    '{ 0,  0, 31, 31}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           ch = 8'd0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           kind;
  logic [7:0]           text_byte;
  logic [31:0]          value;
  logic [5:0]           length;
  logic [1:0]           error_code;
  logic                 last;
  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [LimitW-1:0]    cfg_data = '0;

  // Tokenizer model state and its copy of the limit registers.
  parse_mode_t parse_mode = PM_IDLE;
  logic [31:0] int_accum = 32'd0;
  logic [5:0]  token_len = 6'd0;
  logic [3:0]  keyword_state = KW_NONE;
  logic [5:0]  string_limit = 6'd50;
  logic [5:0]  word_limit = 6'd40;

  result_t tokens_due[$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      sender_idle_pct = 0;
  int      receiver_stall_pct = 0;

  config_line_tokenizer_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .text_byte  (text_byte),
    .value      (value),
    .length     (length),
    .error_code (error_code),
    .last       (last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Character classes.
  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= CH_LOWER && c < CH_LOWER + 8'd26) || (c >= CH_UPPER && c < CH_UPPER + 8'd26);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_DASH || c == CH_UNDER;
  endfunction

  function automatic result_t make_token(input logic [2:0] k, input logic [7:0] tb,
                                         input logic [31:0] v, input logic [5:0] len,
                                         input logic [1:0] err);
    return '{k, tb, v, len, err, 1'b0};
  endfunction

  // Advance the true/false prefix tracker by one word character.
  function automatic logic [3:0] next_keyword(input logic [3:0] m, input logic [7:0] c);
    if (m >= KW_TRUE_START && m < KW_TRUE_DONE && c == TRUE_TEXT[8 * (3 - m) +: 8])
      return m + 4'd1;
    if (m >= KW_FALSE_START && m < KW_FALSE_DONE &&
        c == FALSE_TEXT[8 * (8 - m) +: 8])
      return m + 4'd1;
    return KW_NONE;
  endfunction

  // Tokenize one character: update the model state and return up to two result words.
  function automatic void tokenize_char(input logic [7:0] c, output result_t res[2],
                                        output int n);
    logic restart;
    restart = 1'b0;
    n = 0;
    res[0] = NO_TOKEN;
    res[1] = NO_TOKEN;
    case (parse_mode)
      PM_STRING: begin
        if (c == CH_QUOTE) begin
          if (token_len >= string_limit) begin
            res[n] = make_token(KIND_ERROR, 8'd0, 32'd0, 6'd0, ERR_STRING_LONG);
            parse_mode = PM_SKIP;
          end else begin
            res[n] = make_token(KIND_STRING, 8'd0, 32'd0, token_len, NO_ERROR);
            parse_mode = PM_IDLE;
          end
          n++;
        end else if (c == CH_NUL) begin
          res[n] = make_token(KIND_ERROR, 8'd0, 32'd0, 6'd0, ERR_OPEN_STRING);
          n++;
          parse_mode = PM_IDLE;
        end else begin
          res[n] = make_token(KIND_TEXT, c, 32'd0, 6'd0, NO_ERROR);
          n++;
          if (token_len != 6'd63) token_len++;
        end
      end
      PM_COMMENT, PM_SKIP: begin
        if (c == CH_NUL) parse_mode = PM_IDLE;
      end
      PM_INTEGER: begin
        if (is_digit(c)) begin
          int_accum = int_accum * 32'd10 + {24'd0, c - CH_ZERO};
        end else begin
          res[n] = make_token(KIND_INT, 8'd0, int_accum, 6'd0, NO_ERROR);
          n++;
          parse_mode = PM_IDLE;
          restart = 1'b1;
        end
      end
      PM_WORD: begin
        if (is_word_char(c)) begin
          res[n] = make_token(KIND_TEXT, c, 32'd0, 6'd0, NO_ERROR);
          n++;
          if (token_len != 6'd63) token_len++;
          keyword_state = next_keyword(keyword_state, c);
        end else if (keyword_state == KW_TRUE_DONE || keyword_state == KW_FALSE_DONE) begin
          res[n] = make_token(KIND_BOOL, 8'd0, {31'd0, keyword_state == KW_TRUE_DONE},
                              token_len, NO_ERROR);
          n++;
          parse_mode = PM_IDLE;
          restart = 1'b1;
        end else if (token_len >= word_limit) begin
          res[n] = make_token(KIND_ERROR, 8'd0, 32'd0, 6'd0, ERR_WORD_LONG);
          n++;
          parse_mode = (c == CH_NUL) ? PM_IDLE : PM_SKIP;
        end else begin
          res[n] = make_token(KIND_WORD, 8'd0, 32'd0, token_len, NO_ERROR);
          n++;
          parse_mode = PM_IDLE;
          restart = 1'b1;
        end
      end
      default: begin
        parse_mode = PM_IDLE;
        restart = 1'b1;
      end
    endcase

    // Handle the character as the start of a new token.
    if (restart) begin
      if (is_space(c)) begin
      end else if (c == CH_NUL) begin
        res[n] = make_token(KIND_END, 8'd0, 32'd0, 6'd0, NO_ERROR);
        n++;
      end else if (c == CH_HASH) begin
        res[n] = make_token(KIND_END, 8'd0, 32'd0, 6'd0, NO_ERROR);
        n++;
        parse_mode = PM_COMMENT;
      end else if (c == CH_EQUAL) begin
        res[n] = make_token(KIND_ASSIGN, 8'd0, 32'd0, 6'd0, NO_ERROR);
        n++;
      end else if (c == CH_QUOTE) begin
        parse_mode = PM_STRING;
        token_len = 6'd0;
      end else if (is_digit(c)) begin
        int_accum = {24'd0, c - CH_ZERO};
        parse_mode = PM_INTEGER;
      end else if (is_alpha(c)) begin
        res[n] = make_token(KIND_TEXT, c, 32'd0, 6'd0, NO_ERROR);
        n++;
        parse_mode = PM_WORD;
        token_len = 6'd1;
        keyword_state = (c == "t") ? KW_TRUE_START : (c == "f") ? KW_FALSE_START : KW_NONE;
      end else begin
        res[n] = make_token(KIND_ERROR, c, 32'd0, 6'd0, ERR_BAD_CHAR);
        n++;
        parse_mode = PM_SKIP;
      end
    end

    if (n > 0) res[n - 1].last = 1'b1;
  endfunction

  // Offer one character, wait for the accept, then queue what it should produce.
  task automatic send_char(input logic [7:0] c, input logic typed, input result_t want);
    result_t res[2];
    int      n;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokenize_char(c, res, n);
    if (typed) begin
      tokens_due.push_back(want);
    end else begin
      for (int i = 0; i < n; i++) tokens_due.push_back(res[i]);
    end
  endtask

  // Hold the input idle until every expected word is out, then let the pipe settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_limits(input logic [5:0] str_lim, input logic [5:0] wrd_lim);
    cfg_we <= 1'b1;
    cfg_index <= REG_STRING_LIMIT;
    cfg_data <= str_lim;
    @(posedge clk);
    cfg_index <= REG_WORD_LIMIT;
    cfg_data <= wrd_lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    string_limit = str_lim;
    word_limit = wrd_lim;
  endtask

  // Mostly short tokens; some land right at the limit, a few past saturation.
  function automatic int pick_length(input int limit, input int floor_len);
    int r;
    int lo;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8, floor_len);
    if (r < 92) begin
      lo = (limit - 1 < floor_len) ? floor_len : limit - 1;
      return $urandom_range(limit + 1, lo);
    end
    return $urandom_range(70, 60);
  endfunction

  function automatic logic [7:0] rand_alpha();
    int r;
    r = $urandom_range(51);
    return (r < 26) ? 8'(CH_LOWER + r) : 8'(CH_UPPER + r - 26);
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(63);
    if (r < 52) return rand_alpha();
    if (r < 62) return 8'(CH_ZERO + r - 52);
    return (r == 62) ? CH_DASH : CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_space();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
  endfunction

  // Any byte but the line end and the quote.
  function automatic logic [7:0] rand_string_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255, 1));
    while (b == CH_QUOTE) b = 8'($urandom_range(255, 1));
    return b;
  endfunction

  // Build one line (mostly well formed, some noise), send it, and count its live characters.
  task automatic send_random_line(inout int count);
    logic [7:0] line[$];
    int         n_tok;
    int         len;
    int         r;
    int         ignored;
    string      kw;
    ignored = 0;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(10, 1)) line.push_back(8'($urandom_range(255)));
    end else begin
      n_tok = $urandom_range(6, 1);
      repeat (n_tok) begin
        repeat ($urandom_range(2)) line.push_back(rand_space());
        r = $urandom_range(99);
        if (r < 12) begin
          kw = keyword_forms[$urandom_range(keyword_forms.size() - 1)];
          for (int i = 0; i < kw.len(); i++) line.push_back(kw[i]);
        end else if (r < 32) begin
          len = pick_length(word_limit, 1);
          line.push_back(rand_alpha());
          repeat (len - 1) line.push_back(rand_word_char());
        end else if (r < 52) begin
          repeat ($urandom_range(12, 1)) line.push_back(8'(CH_ZERO + $urandom_range(9)));
        end else if (r < 72) begin
          len = pick_length(string_limit, 0);
          line.push_back(CH_QUOTE);
          repeat (len) line.push_back(rand_string_byte());
          if ($urandom_range(99) >= 8) line.push_back(CH_QUOTE);
        end else if (r < 82) begin
          line.push_back(CH_EQUAL);
        end else if (r < 90) begin
          line.push_back(CH_HASH);
          len = $urandom_range(6);
          repeat (len) line.push_back(8'($urandom_range(255, 1)));
          ignored += len;
        end else begin
          line.push_back(8'($urandom_range(255, 1)));
        end
      end
      line.push_back(CH_NUL);
    end
    count += line.size() - ignored;
    foreach (line[i]) send_char(line[i], 1'b0, NO_TOKEN);
  endtask

  // Receiver back-pressure.
  always @(posedge clk) out_stall <= ($urandom_range(99) < receiver_stall_pct);

  // Compare each accepted result word with the oldest expectation, field by field.
  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{kind, text_byte, value, length, error_code, last};
      if (tokens_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected word: kind %0d byte %h value %h len %0d err %0d last %0b",
                   got.kind, got.text_byte, got.value, got.length, got.error_code, got.last);
      end else begin
        want = tokens_due.pop_front();
        if (got.kind !== want.kind || got.text_byte !== want.text_byte ||
            got.value !== want.value || got.length !== want.length ||
            got.error_code !== want.error_code || got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch at cycle %0d", cycle_count);
            $display("  expected kind %0d byte %h value %h len %0d err %0d last %0b",
                     want.kind, want.text_byte, want.value, want.length, want.error_code,
                     want.last);
            $display("  actual   kind %0d byte %h value %h len %0d err %0d last %0b",
                     got.kind, got.text_byte, got.value, got.length, got.error_code,
                     got.last);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** config_line_tokenizer_top: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int  phase_items;
    logic drained;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i])
      send_char(DIRECTED_ROWS[i].c, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) begin
        phase_plan[p][0] = $urandom_range(63);
        phase_plan[p][1] = $urandom_range(63);
      end
      // Phase 0 runs on the reset limits; every later phase rewrites both registers.
      if (p != 0) load_limits(6'(phase_plan[p][0]), 6'(phase_plan[p][1]));
      sender_idle_pct = phase_plan[p][2];
      receiver_stall_pct <= phase_plan[p][3];
      phase_items = 0;
      drained = 1'b0;
      while (phase_items < ITEMS_PER_PHASE) begin
        send_random_line(phase_items);
        // Pause mid-phase until the output side has caught up completely.
        if (!drained && phase_items >= ITEMS_PER_PHASE / 2) begin
          drain_results();
          drained = 1'b1;
        end
      end
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("** config_line_tokenizer_top: PASSED **");
    end else begin
      $display("** config_line_tokenizer_top: FAILED **");
    end
    $finish;
  end

endmodule
